[hdl/mbps_pkg.sv]
// Shared types, constants and helpers of the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

   // Depth of the byte window, one cell per byte.
   localparam int MaxSig = 32;
   // Signature bytes held in the configuration registers.
   localparam int RegBytes = 32;
   // Longest signature that can be used.
   localparam int LenCap = (MaxSig < RegBytes) ? MaxSig : RegBytes;

   localparam int ByteW = 8;
   localparam int WordW = 64;
   localparam int WordBytes = WordW / ByteW;
   localparam int NumWords = RegBytes / WordBytes;
   localparam int SigIdxW = $clog2(RegBytes);
   localparam int LenW = 6;
   localparam int CountW = 32;
   localparam int CsrIdxW = 3;

   typedef logic [ByteW-1:0] byte_type;
   typedef logic [LenW-1:0] len_type;
   typedef logic [CountW-1:0] count_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SIG_0_7   = 3'd0,
      CSR_SIG_8_15  = 3'd1,
      CSR_SIG_16_23 = 3'd2,
      CSR_SIG_24_31 = 3'd3,
      CSR_CARE_MASK = 3'd4,
      CSR_SIG_LEN   = 3'd5
   } csr_index_type;

   // Per-cell view of the signature: the byte this window position must hold, and whether it is compared.
   typedef struct packed {
      logic     care;
      byte_type sig_byte;
   } cell_cfg_type;

   // Signature length in use: zero counts as one, capped at LenCap.
   function automatic len_type used_length(input len_type len);
      len_type n;
      n = len;
      if (n == '0) begin
         n = len_type'(1);
      end
      if (n > len_type'(LenCap)) begin
         n = len_type'(LenCap);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[hdl/mbps_cell.sv]
// One window cell: holds one byte, passes it on, and compares it.
`default_nettype none

module mbps_cell (
   input  wire logic                  clock,
   input  wire logic                  shift_en,
   input  wire mbps_pkg::byte_type    byte_in,
   input  wire mbps_pkg::cell_cfg_type cfg,
   output mbps_pkg::byte_type         byte_out,
   output logic                       hit
);

   mbps_pkg::byte_type byte_ff;
   mbps_pkg::byte_type byte_in_w;

   // The byte moves one cell older with every accepted transfer.
   assign byte_in_w = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_w;
   end

   assign byte_out = byte_ff;
   assign hit = !cfg.care || (byte_ff == cfg.sig_byte);

endmodule

`default_nettype wire

[hdl/masked_byte_pattern_scanner.sv]
// Top level of the masked byte pattern scanner: window cells, region state, result register.
//
//   Port group   Direction   Handshake            Payload
//   req_         in          req_valid/req_ready  req_data_byte[7:0], req_region_end
//   rsp_         out         rsp_valid/rsp_ready  rsp_match_found, rsp_match_offset[31:0]
//   csr_         in          csr_we               csr_index[2:0], csr_wdata[63:0]
//
// One byte is taken per cycle unless stalled. A byte shifts into the cell chain at its
// transfer; in the following cycle the cells compare against the signature and the
// region state is updated, so a region's result enters the output register as its last
// byte leaves the compare stage. The only stall is a finished result that still waits
// in the output register when the next region end reaches the compare stage.
// Reset clears the configuration to its defaults and all control state; the window
// bytes themselves are not cleared, since the byte count masks them.
`default_nettype none

module masked_byte_pattern_scanner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_region_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_match_found,
   output logic [31:0]      rsp_match_offset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   // Configuration registers.
   logic [mbps_pkg::NumWords-1:0][mbps_pkg::WordW-1:0] sig_word_ff;
   logic [mbps_pkg::RegBytes-1:0]                      care_mask_ff;
   mbps_pkg::len_type                                  sig_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_word_ff  <= '0;
         care_mask_ff <= '0;
         sig_len_ff   <= mbps_pkg::len_type'(1);
      end else if (csr_we) begin
         case (mbps_pkg::csr_index_type'(csr_index))
            mbps_pkg::CSR_SIG_0_7:   sig_word_ff[0] <= csr_wdata;
            mbps_pkg::CSR_SIG_8_15:  sig_word_ff[1] <= csr_wdata;
            mbps_pkg::CSR_SIG_16_23: sig_word_ff[2] <= csr_wdata;
            mbps_pkg::CSR_SIG_24_31: sig_word_ff[3] <= csr_wdata;
            mbps_pkg::CSR_CARE_MASK: care_mask_ff <= csr_wdata[mbps_pkg::RegBytes-1:0];
            mbps_pkg::CSR_SIG_LEN:   sig_len_ff <= csr_wdata[mbps_pkg::LenW-1:0];
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   mbps_pkg::len_type sig_n;
   logic [mbps_pkg::RegBytes*mbps_pkg::ByteW-1:0] sig_flat;

   assign sig_n    = mbps_pkg::used_length(sig_len_ff);
   assign sig_flat = sig_word_ff;

   // Handshake and compare-stage control.
   logic req_xfer;
   logic stall;
   logic s1_valid_ff, s1_valid_in;
   logic s1_last_ff, s1_last_in;
   logic restart_ff, restart_in;
   mbps_pkg::count_type count_ff, count_in;

   // A region end in the compare stage needs room in the output register.
   assign stall     = s1_valid_ff && s1_last_ff && rsp_valid && !rsp_ready;
   assign req_ready = !stall;
   assign req_xfer  = req_valid && req_ready;

   // Cell chain: cell 0 holds the newest byte. The signature is reversed onto the
   // cells so that signature byte 0 lines up with the oldest byte of the window.
   mbps_pkg::byte_type                      chain_byte [mbps_pkg::MaxSig+1];
   logic [mbps_pkg::MaxSig-1:0]             cell_hit;

   assign chain_byte[0] = req_data_byte;

   for (genvar k = 0; k < mbps_pkg::MaxSig; k++) begin : g_cell
      mbps_pkg::cell_cfg_type     cfg;
      logic [mbps_pkg::LenW:0]    pos_rev;
      logic                       in_use;

      always_comb begin
         pos_rev      = {1'b0, sig_n} - (mbps_pkg::LenW+1)'(1) - (mbps_pkg::LenW+1)'(k);
         in_use       = (mbps_pkg::LenW+1)'(k) < {1'b0, sig_n};
         cfg.sig_byte = sig_flat[{pos_rev[mbps_pkg::SigIdxW-1:0], 3'b000} +:
                                 mbps_pkg::ByteW];
         cfg.care     = in_use && care_mask_ff[pos_rev[mbps_pkg::SigIdxW-1:0]];
      end

      mbps_cell u_cell (
         .clock    (clock),
         .shift_en (req_xfer),
         .byte_in  (chain_byte[k]),
         .cfg      (cfg),
         .byte_out (chain_byte[k+1]),
         .hit      (cell_hit[k])
      );
   end

   // Byte count of the region, including the byte now in the compare stage.
   always_comb begin
      count_in    = count_ff;
      restart_in  = restart_ff;
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      if (!stall) begin
         s1_valid_in = req_xfer;
         s1_last_in  = req_region_end;
      end
      if (req_xfer) begin
         restart_in = req_region_end;
         if (restart_ff) begin
            count_in = mbps_pkg::count_type'(1);
         end else if (count_ff != '1) begin
            count_in = count_ff + mbps_pkg::count_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         restart_ff  <= 1'b1;
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         restart_ff  <= restart_in;
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
      end
   end

   // Compare stage: a window counts only once the region holds L bytes.
   logic                window_hit;
   mbps_pkg::count_type hit_offset;
   logic                seen_ff, seen_in;
   mbps_pkg::count_type first_ff, first_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   mbps_pkg::count_type offset_ff, offset_in;
   logic                commit;

   assign commit     = s1_valid_ff && !stall;
   assign window_hit = (count_ff >= mbps_pkg::count_type'(sig_n)) && (&cell_hit);
   assign hit_offset = count_ff - mbps_pkg::count_type'(sig_n);

   always_comb begin
      seen_in      = seen_ff;
      first_in     = first_ff;
      found_in     = found_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (commit) begin
         if (!seen_ff && window_hit) begin
            seen_in  = 1'b1;
            first_in = hit_offset;
         end
         if (s1_last_ff) begin
            // Report the region and start the next one clean.
            rsp_valid_in = 1'b1;
            found_in     = seen_in;
            offset_in    = first_in;
            seen_in      = 1'b0;
            first_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_found  = found_ff;
   assign rsp_match_offset = offset_ff;

   // A result without a match always carries offset zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_match_offset == '0)
      else $error("result without match has a nonzero offset");

   // Input back-pressure only comes from a result that is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && s1_valid_ff && s1_last_ff)
      else $error("input stalled without a waiting result");

   // A region end leaving the compare stage shows up as a result.
   assert property (@(posedge clock) disable iff (reset)
      commit && s1_last_ff |=> rsp_valid && !seen_ff)
      else $error("region end did not produce a result");

   // The region offset is only nonzero once a match was recorded.
   assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> first_ff == '0)
      else $error("first offset set without a recorded match");

endmodule

`default_nettype wire

[bench/mbps_match_tracker_pkg.sv]
// Scoreboard class for the scanner: window and region state, and the queue of region results.
package mbps_match_tracker_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                found;
      mbps_pkg::count_type offset;
   } region_result_type;

   class region_match_tracker;
      logic [mbps_pkg::WordW-1:0] sig_word [mbps_pkg::NumWords];
      logic [31:0]                care;
      mbps_pkg::len_type          len_reg;
      mbps_pkg::byte_type         window [mbps_pkg::MaxSig];
      mbps_pkg::count_type        seen;
      logic                       matched;
      mbps_pkg::count_type        first_off;
      region_result_type          expected_results [$];
      int unsigned                errors;

      function new();
         foreach (sig_word[i]) sig_word[i] = '0;
         care = '0;
         len_reg = mbps_pkg::len_type'(1);
         errors = 0;
         clear_region();
      endfunction

      function void clear_region();
         foreach (window[k]) window[k] = '0;
         seen = '0;
         matched = 1'b0;
         first_off = '0;
      endfunction

      function void write_reg(input logic [mbps_pkg::CsrIdxW-1:0] idx,
                              input logic [mbps_pkg::WordW-1:0] value);
         case (idx)
            mbps_pkg::CSR_SIG_0_7, mbps_pkg::CSR_SIG_8_15,
            mbps_pkg::CSR_SIG_16_23, mbps_pkg::CSR_SIG_24_31: begin
               sig_word[int'(idx)] = value;
            end
            mbps_pkg::CSR_CARE_MASK: begin
               care = value[31:0];
            end
            mbps_pkg::CSR_SIG_LEN: begin
               len_reg = value[mbps_pkg::LenW-1:0];
            end
            default: begin
               // Indexes past the register list change nothing.
            end
         endcase
      endfunction

      function int unsigned window_len();
         int unsigned n;
         n = len_reg;
         if (n == 0) n = 1;
         if (n > mbps_pkg::LenCap) n = mbps_pkg::LenCap;
         return n;
      endfunction

      function mbps_pkg::byte_type sig_at(input int unsigned j);
         return sig_word[j / mbps_pkg::WordBytes]
                        [(j % mbps_pkg::WordBytes) * mbps_pkg::ByteW +: mbps_pkg::ByteW];
      endfunction

      // Signature byte 0 lines up with the oldest byte of the window.
      function logic window_hits(input int unsigned n);
         for (int unsigned j = 0; j < n; j++) begin
            if (care[j] && window[n - 1 - j] !== sig_at(j)) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void take_byte(input mbps_pkg::byte_type b, input logic last);
         int unsigned n;
         region_result_type r;
         n = window_len();
         for (int k = mbps_pkg::MaxSig - 1; k > 0; k--) window[k] = window[k - 1];
         window[0] = b;
         if (seen != '1) seen++;
         if (!matched && seen >= n && window_hits(n)) begin
            matched = 1'b1;
            first_off = seen - mbps_pkg::count_type'(n);
         end
         if (last) begin
            r.found = matched;
            r.offset = matched ? first_off : '0;
            expected_results.insert(expected_results.size(), r);
            clear_region();
         end
      endfunction

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_match(input logic found, input mbps_pkg::count_type offset);
         region_result_type r;
         if (expected_results.size() == 0) begin
            report($sformatf("result with no region pending: found=%b offset=%0d",
                             found, offset));
            return;
         end
         r = expected_results[0];
         expected_results.delete(0);
         if (found !== r.found) begin
            report($sformatf("match_found %b, expected %b", found, r.found));
         end
         if (offset !== r.offset) begin
            report($sformatf("match_offset %0d, expected %0d", offset, r.offset));
         end
      endtask

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

endpackage

[bench/masked_byte_pattern_scanner_test.sv]
// Self-checking testbench of the masked byte pattern scanner with random regions and stalls.
module masked_byte_pattern_scanner_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Run shape. Each random phase runs one signature setting over a batch of regions.
   localparam int NumPhases = 12;
   localparam int ItemsPerPhase = 128;
   // Cycles to let the pipeline settle once every result has come back.
   localparam int SettleCycles = 4;
   localparam int EndCycles = 10;
   // Cycles without any transfer on either channel before the run is declared hung.
   localparam int StallLimit = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_data_byte = '0;
   logic              req_region_end = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_match_found;
   logic [31:0]       rsp_match_offset;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [63:0]       csr_wdata = '0;

   mbps_match_tracker_pkg::region_match_tracker tracker;

   // Idle percentages of the sender and the receiver, changed between phases.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          stall_cycles = 0;

   // Signature setting that the next configuration pass writes.
   logic [mbps_pkg::WordW-1:0] cfg_word [mbps_pkg::NumWords];
   logic [31:0]                cfg_care;
   mbps_pkg::len_type          cfg_len;

   // Bytes of the region under construction, oldest first.
   mbps_pkg::byte_type region_bytes [$];

   masked_byte_pattern_scanner dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_region_end   (req_region_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Monitor and receiver. Every value read here is the one that was present at the
   // rising edge, since all inputs are driven with nonblocking assignments. The input
   // transfer is noted before the result is checked, so an expectation is always in
   // place before the result it belongs to is looked at.
   always @(posedge clock) begin
      logic moved;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            tracker.take_byte(req_data_byte, req_region_end);
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            tracker.check_match(rsp_match_found, rsp_match_offset);
            moved = 1'b1;
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: a run in which nothing moves for too long has hung.
   initial begin
      wait (stall_cycles >= StallLimit);
      $display("masked_byte_pattern_scanner regression: fail");
      $finish;
   end

   // One register write. The write enable stays high across back-to-back writes so
   // that it never gets two assignments in the same step.
   task automatic write_reg(input logic [mbps_pkg::CsrIdxW-1:0] idx,
                            input logic [mbps_pkg::WordW-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_reg(idx, value);
   endtask

   // Writes every register from the cfg_ variables. Unused upper bits of the narrow
   // registers carry random junk, which the block must drop. With with_junk set, a
   // write to an index beyond the register list goes first; it must have no effect.
   task automatic write_config(input logic with_junk);
      if (with_junk) begin
         write_reg((mbps_pkg::CsrIdxW)'(int'(mbps_pkg::CSR_SIG_LEN) + 1 + $urandom_range(1)),
                   {$urandom, $urandom});
      end
      for (int i = 0; i < mbps_pkg::NumWords; i++) begin
         write_reg((mbps_pkg::CsrIdxW)'(int'(mbps_pkg::CSR_SIG_0_7) + i), cfg_word[i]);
      end
      write_reg(mbps_pkg::CSR_CARE_MASK, {$urandom, cfg_care});
      write_reg(mbps_pkg::CSR_SIG_LEN, {$urandom, 26'($urandom), cfg_len});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one byte and returns once its transfer has happened. Valid is only
   // lowered when the sender decides to idle, so consecutive bytes keep it high.
   task automatic send_byte(input mbps_pkg::byte_type b, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_region_end <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Holds the sender off until every region result has come back, then lets the
   // pipeline settle. Configuration writes are only made after this. One edge goes
   // by first so that the monitor has noted the last transfer.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Sends the region queue, the last byte marked as the region end. With
   // pause_before_end set, the sender waits for all older results before that byte.
   task automatic send_region(input logic pause_before_end);
      for (int i = 0; i < region_bytes.size(); i++) begin
         if (pause_before_end && i == region_bytes.size() - 1) wait_for_results();
         send_byte(region_bytes[i], i == region_bytes.size() - 1);
      end
   endtask

   function automatic void add_noise(input int unsigned count);
      repeat (count) region_bytes.insert(region_bytes.size(), mbps_pkg::byte_type'($urandom));
   endfunction

   // Appends one copy of the signature with random bytes in the wildcard places.
   // A broken copy has one cared byte altered so that it just misses.
   function automatic void add_instance(input logic broken);
      int unsigned n;
      int unsigned cared [$];
      mbps_pkg::byte_type piece [$];
      int unsigned k;
      n = tracker.window_len();
      for (int unsigned j = 0; j < n; j++) begin
         if (tracker.care[j]) begin
            piece.insert(piece.size(), tracker.sig_at(j));
            cared.insert(cared.size(), j);
         end else begin
            piece.insert(piece.size(), mbps_pkg::byte_type'($urandom));
         end
      end
      if (broken && cared.size() > 0) begin
         k = cared[$urandom_range(cared.size() - 1)];
         piece[k] = piece[k] ^ mbps_pkg::byte_type'($urandom_range(1, 255));
      end
      foreach (piece[i]) region_bytes.insert(region_bytes.size(), piece[i]);
   endfunction

   // Most regions hold a planted signature; the rest are broken copies, regions
   // shorter than the signature, and plain noise.
   function automatic void build_region();
      int unsigned n;
      int unsigned kind;
      n = tracker.window_len();
      kind = $urandom_range(99);
      region_bytes.delete();
      if (kind < 60) begin
         add_noise(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12));
         add_instance(1'b0);
         if ($urandom_range(1)) add_noise($urandom_range(1, 8));
         if ($urandom_range(9) < 3) add_instance($urandom_range(1));
      end else if (kind < 75) begin
         add_noise($urandom_range(0, 6));
         add_instance(1'b1);
         add_noise($urandom_range(0, 4));
      end else if (kind < 85) begin
         add_noise((n > 1) ? $urandom_range(1, n - 1) : 1);
      end else begin
         add_noise($urandom_range(1, 40));
      end
   endfunction

   // Signature setting of a random phase. The first few phases hit the extremes:
   // longest exact signature, one wildcard byte, length zero, length past the cap,
   // and all-ones and all-zeros signature bytes. Later phases mostly use short ones.
   function automatic void choose_config(input int p);
      foreach (cfg_word[i]) cfg_word[i] = {$urandom, $urandom};
      case (p)
         0: begin
            cfg_len = mbps_pkg::len_type'(32);
            cfg_care = '1;
         end
         1: begin
            cfg_len = mbps_pkg::len_type'(1);
            cfg_care = '0;
         end
         2: begin
            cfg_len = '0;
            cfg_care = '1;
         end
         3: begin
            cfg_len = '1;
            cfg_care = '0;
         end
         4: begin
            foreach (cfg_word[i]) cfg_word[i] = '1;
            cfg_len = mbps_pkg::len_type'(33);
            cfg_care = $urandom;
         end
         5: begin
            foreach (cfg_word[i]) cfg_word[i] = '0;
            cfg_len = mbps_pkg::len_type'($urandom_range(1, 8));
            cfg_care = $urandom;
         end
         default: begin
            cfg_len = ($urandom_range(3) == 0) ? mbps_pkg::len_type'($urandom_range(0, 63))
                                               : mbps_pkg::len_type'($urandom_range(1, 10));
            cfg_care = $urandom & ($urandom_range(1) ? $urandom : 32'hFFFF_FFFF);
         end
      endcase
   endfunction

   // Directed regions: the reset setting (one wildcard byte, every window matches),
   // a region shorter than the signature, a match on the window that ends on the
   // region's last byte, a later match that must not replace the first, a length of
   // zero, and a write beyond the register list.
   task automatic run_directed();
      region_bytes = '{8'h00};
      send_region(1'b0);
      region_bytes = '{8'hFF, 8'h80};
      send_region(1'b0);
      wait_for_results();

      cfg_word[0] = 64'h0000_0000_0033_2211;
      cfg_word[1] = '0;
      cfg_word[2] = '0;
      cfg_word[3] = '0;
      cfg_care = 32'h0000_0005;
      cfg_len = mbps_pkg::len_type'(3);
      write_config(1'b0);
      region_bytes = '{8'h11, 8'h33};
      send_region(1'b0);
      region_bytes = '{8'h5A, 8'h11, 8'h99, 8'h33};
      send_region(1'b0);
      region_bytes = '{8'h11, 8'h22, 8'h33, 8'h11, 8'h44, 8'h33};
      send_region(1'b0);
      wait_for_results();

      cfg_len = '0;
      cfg_care = 32'h0000_0001;
      write_config(1'b1);
      region_bytes = '{8'h00, 8'h11, 8'h11};
      send_region(1'b0);
      region_bytes = '{8'hFF, 8'h00};
      send_region(1'b0);
      wait_for_results();
   endtask

   initial begin
      int  phase_items;
      logic paused;
      logic pause_now;

      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 25;
      recv_idle_pct = 60;
      run_directed();

      for (int p = 0; p < NumPhases; p++) begin
         // A third of the phases each: sender light and receiver heavy idling,
         // then the reverse, then no idling at all.
         if (p < NumPhases / 3) begin
            send_idle_pct = 25;
            recv_idle_pct = 60;
         end else if (p < 2 * NumPhases / 3) begin
            send_idle_pct = 60;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         choose_config(p);
         write_config(p % 3 == 0);
         phase_items = 0;
         paused = 1'b0;
         while (phase_items < ItemsPerPhase) begin
            build_region();
            // Once per phase, hold the last byte of a region until the scanner
            // has handed back every earlier result.
            pause_now = !paused && phase_items >= ItemsPerPhase / 2;
            if (pause_now) paused = 1'b1;
            send_region(pause_now);
            phase_items += region_bytes.size();
         end
         wait_for_results();
      end

      repeat (EndCycles) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("masked_byte_pattern_scanner regression: pass");
      end else begin
         $display("masked_byte_pattern_scanner regression: fail");
      end
      $finish;
   end

endmodule
